// ===== sv/rsp_pkg.sv =====
// Shared types and constants for the RLC STATUS PDU parser.
package rsp_pkg;

    localparam int SN_W      = 18;
    localparam int SO_W      = 16;
    localparam int RANGE_W   = 8;
    localparam int BYTE_W    = 8;
    localparam int ACC_W     = 24;
    localparam int CNT_W     = 3;
    localparam int TDATA_W   = 64;
    localparam int IN_DATA_W = 8;

    // Octets gathered before an item completes
    localparam logic [CNT_W-1:0] CNT_MAX      = 3'd4;
    localparam logic [CNT_W-1:0] ACK_BYTES    = 3'd3;
    localparam logic [CNT_W-1:0] NACK_BYTES_S = 3'd2;
    localparam logic [CNT_W-1:0] NACK_BYTES_L = 3'd3;
    localparam logic [CNT_W-1:0] SO_BYTES     = 3'd4;

    typedef enum logic [1:0] {
        PH_ACK   = 2'd0,
        PH_NACK  = 2'd1,
        PH_SO    = 2'd2,
        PH_RANGE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ACK        = 2'd0,
        KIND_NACK       = 2'd1,
        KIND_NOT_STATUS = 2'd2,
        KIND_TRUNC      = 2'd3
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] pdu_byte;
        logic              last_byte;
    } item_t;

    typedef struct packed {
        kind_t              kind;
        logic [SN_W-1:0]    seq_num;
        logic               so_valid;
        logic [SO_W-1:0]    so_start;
        logic [SO_W-1:0]    so_end;
        logic               range_valid;
        logic [RANGE_W-1:0] nack_range;
        logic               last;
    } result_t;

endpackage

// ===== sv/rsp_in_reg.sv =====
// Input register: holds one accepted octet until the parser takes it.
module rsp_in_reg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rsp_pkg::IN_DATA_W-1:0] s_tdata,   // [7:0] pdu_byte
    input  logic                          s_tlast,   // last_byte
    input  logic                          advance,
    output rsp_pkg::item_t                item,
    output logic                          item_valid
);

    logic           valid_reg;
    logic           valid_next;
    rsp_pkg::item_t item_reg;
    logic           take;

    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.pdu_byte  <= s_tdata[rsp_pkg::BYTE_W-1:0];
            item_reg.last_byte <= s_tlast;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

// ===== sv/rsp_parse_core.sv =====
// Parser state and the per-octet field extraction logic.
module rsp_parse_core (
    input  logic             clk,
    input  logic             rst_n,
    input  rsp_pkg::item_t   item,
    input  logic             item_valid,
    input  logic             advance,
    input  logic             short_sn,
    output logic             emit,
    output rsp_pkg::result_t result
);

    rsp_pkg::phase_t                 phase_reg, phase_next;
    logic [rsp_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [rsp_pkg::ACC_W-1:0]       acc_reg, acc_next;
    logic                            done_reg, done_next;
    logic [rsp_pkg::SN_W-1:0]        sn_reg, sn_next;
    logic [2:0]                      flags_reg, flags_next;
    logic [rsp_pkg::SO_W-1:0]        so_start_reg, so_start_next;
    logic [rsp_pkg::SO_W-1:0]        so_end_reg, so_end_next;

    logic [rsp_pkg::ACC_W+rsp_pkg::BYTE_W-1:0] acc_word;
    logic [rsp_pkg::CNT_W-1:0]       cnt_inc;
    logic                            lb;
    logic                            fire;
    logic                            blk;
    logic                            chk_lb;
    logic                            trunc;
    logic                            restart;
    logic [rsp_pkg::RANGE_W-1:0]     blk_rng;
    logic [rsp_pkg::SN_W-1:0]        ack_sn;
    logic                            ack_e1;

    assign lb       = item.last_byte;
    assign acc_word = {acc_reg, item.pdu_byte};
    assign cnt_inc  = (cnt_reg < rsp_pkg::CNT_MAX) ? cnt_reg + 3'd1 : rsp_pkg::CNT_MAX;
    assign ack_sn   = short_sn ? {6'd0, acc_word[19:8]} : acc_word[19:2];
    assign ack_e1   = short_sn ? acc_word[7] : acc_word[1];

    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        done_next     = done_reg;
        sn_next       = sn_reg;
        flags_next    = flags_reg;
        so_start_next = so_start_reg;
        so_end_next   = so_end_reg;
        fire          = 1'b0;
        blk           = 1'b0;
        chk_lb        = 1'b0;
        trunc         = 1'b0;
        restart       = 1'b0;
        blk_rng       = '0;
        result        = '0;

        if (done_reg)
        begin
            // skip trailing octets until the PDU ends
            restart = lb;
        end
        else if (phase_reg == rsp_pkg::PH_ACK && cnt_reg == '0 &&
                 item.pdu_byte[7:4] != 4'd0)
        begin
            fire          = 1'b1;
            result.kind   = rsp_pkg::KIND_NOT_STATUS;
            result.last   = 1'b1;
            restart       = lb;
            done_next     = !lb;
        end
        else
        begin
            acc_next = acc_word[rsp_pkg::ACC_W-1:0];
            cnt_next = cnt_inc;
            case (phase_reg)
                rsp_pkg::PH_ACK:
                begin
                    if (cnt_inc >= rsp_pkg::ACK_BYTES)
                    begin
                        if (ack_e1 && lb)
                        begin
                            trunc = 1'b1;
                        end
                        else
                        begin
                            fire           = 1'b1;
                            result.kind    = rsp_pkg::KIND_ACK;
                            result.seq_num = ack_sn;
                            result.last    = !ack_e1;
                            cnt_next       = '0;
                            acc_next       = '0;
                            if (ack_e1)
                            begin
                                phase_next = rsp_pkg::PH_NACK;
                            end
                            else
                            begin
                                restart   = lb;
                                done_next = !lb;
                            end
                        end
                    end
                    else
                    begin
                        chk_lb = 1'b1;
                    end
                end
                rsp_pkg::PH_NACK:
                begin
                    if (cnt_inc >= (short_sn ? rsp_pkg::NACK_BYTES_S
                                             : rsp_pkg::NACK_BYTES_L))
                    begin
                        if (short_sn)
                        begin
                            sn_next    = {6'd0, acc_word[15:4]};
                            flags_next = acc_word[3:1];
                        end
                        else
                        begin
                            sn_next    = acc_word[23:6];
                            flags_next = acc_word[5:3];
                        end
                        so_start_next = '0;
                        so_end_next   = '0;
                        cnt_next      = '0;
                        acc_next      = '0;
                        if (flags_next[1])
                        begin
                            phase_next = rsp_pkg::PH_SO;
                            chk_lb     = 1'b1;
                        end
                        else if (flags_next[0])
                        begin
                            phase_next = rsp_pkg::PH_RANGE;
                            chk_lb     = 1'b1;
                        end
                        else
                        begin
                            blk = 1'b1;
                        end
                    end
                    else
                    begin
                        chk_lb = 1'b1;
                    end
                end
                rsp_pkg::PH_SO:
                begin
                    if (cnt_inc >= rsp_pkg::SO_BYTES)
                    begin
                        so_start_next = acc_word[31:16];
                        so_end_next   = acc_word[15:0];
                        cnt_next      = '0;
                        acc_next      = '0;
                        if (flags_reg[0])
                        begin
                            phase_next = rsp_pkg::PH_RANGE;
                            chk_lb     = 1'b1;
                        end
                        else
                        begin
                            blk = 1'b1;
                        end
                    end
                    else
                    begin
                        chk_lb = 1'b1;
                    end
                end
                rsp_pkg::PH_RANGE:
                begin
                    blk     = 1'b1;
                    blk_rng = item.pdu_byte;
                end
                default:
                begin
                    chk_lb = 1'b1;
                end
            endcase

            // NACK block complete
            if (blk)
            begin
                if (flags_next[2] && lb)
                begin
                    trunc = 1'b1;
                end
                else
                begin
                    fire               = 1'b1;
                    result.kind        = rsp_pkg::KIND_NACK;
                    result.seq_num     = sn_next;
                    result.so_valid    = flags_next[1];
                    result.so_start    = flags_next[1] ? so_start_next : '0;
                    result.so_end      = flags_next[1] ? so_end_next : '0;
                    result.range_valid = flags_next[0];
                    result.nack_range  = flags_next[0] ? blk_rng : '0;
                    result.last        = !flags_next[2];
                    cnt_next           = '0;
                    acc_next           = '0;
                    if (flags_next[2])
                    begin
                        phase_next = rsp_pkg::PH_NACK;
                    end
                    else
                    begin
                        restart   = lb;
                        done_next = !lb;
                    end
                end
            end

            if (chk_lb && lb)
            begin
                trunc = 1'b1;
            end

            if (trunc)
            begin
                fire        = 1'b1;
                result      = '0;
                result.kind = rsp_pkg::KIND_TRUNC;
                result.last = 1'b1;
                restart     = 1'b1;
            end
        end

        if (restart)
        begin
            phase_next = rsp_pkg::PH_ACK;
            cnt_next   = '0;
            acc_next   = '0;
            done_next  = 1'b0;
        end
    end

    assign emit = item_valid && fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rsp_pkg::PH_ACK;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            done_reg  <= done_next;
        end
    end

    // NACK block fields are always written before they are read
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sn_reg       <= sn_next;
            flags_reg    <= flags_next;
            so_start_reg <= so_start_next;
            so_end_reg   <= so_end_next;
        end
    end

endmodule

// ===== sv/rsp_out_reg.sv =====
// Result register: holds one result item until the receiver takes it.
module rsp_out_reg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  rsp_pkg::result_t            result,
    output logic                        free,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rsp_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast
);

    logic             valid_reg;
    logic             valid_next;
    rsp_pkg::result_t res_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, res_reg.nack_range, res_reg.range_valid, res_reg.so_end,
                       res_reg.so_start, res_reg.so_valid, res_reg.seq_num};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;

endmodule

// ===== sv/rlc_status_pdu_parser.sv =====
// Top level of the NR RLC AM STATUS PDU parser.
//
// Octets of a STATUS PDU enter on the s_ group, one per item, with s_tlast
// marking the final octet. Each result item leaves on the m_ group: the kind
// in m_tuser, the fields in m_tdata, and m_tlast on the final result of a PDU.
// The cfg_ channel writes short_sn (1 = 12-bit SNs, 0 = 18-bit); it is always
// ready and should be written between PDUs.
//
// An octet is taken into an input register, parsed in the next cycle, and its
// result, if any, is loaded into the result register that drives m_tvalid. One
// octet is accepted every cycle unless the input register holds an octet
// whose result waits for a full result register.
//
// When the receiver stalls, the result register holds and the input register
// still takes one more octet; after that s_tready drops until the result is
// taken. Octets that yield no result pass through even while stalled.
// Reset empties both registers, returns the parser to the PDU header and sets
// short_sn to 1.
module rlc_status_pdu_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rsp_pkg::IN_DATA_W-1:0] s_tdata,   // [7:0] pdu_byte
    input  logic                          s_tlast,   // last_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [17:0] seq_num, [18] so_valid, [34:19] so_start, [50:35] so_end,
    // [51] range_valid, [59:52] nack_range, [63:60] zero
    output logic [rsp_pkg::TDATA_W-1:0]   m_tdata,
    output logic [1:0]                    m_tuser,   // [1:0] kind
    output logic                          m_tlast,   // last
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data   // short_sn
);

    rsp_pkg::item_t   item;
    logic             item_valid;
    logic             advance;
    logic             emit;
    logic             out_free;
    rsp_pkg::result_t result;
    logic             short_sn_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_sn_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            short_sn_reg <= cfg_data;
        end
    end

    // advance unless a result is due and the result register is still full
    assign advance = item_valid && (!emit || out_free);

    rsp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item       (item),
        .item_valid (item_valid)
    );

    rsp_parse_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .advance    (advance),
        .short_sn   (short_sn_reg),
        .emit       (emit),
        .result     (result)
    );

    rsp_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && emit),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_end_kinds_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == rsp_pkg::KIND_NOT_STATUS || m_tuser == rsp_pkg::KIND_TRUNC)
        |-> m_tlast)
        else $error("terminal result without last");

    a_no_opt_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != rsp_pkg::KIND_NACK |-> !m_tdata[18] && !m_tdata[51])
        else $error("optional fields set outside a NACK block");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit && m_tvalid && !m_tready |-> !advance)
        else $error("pending result overwritten");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |=> m_tvalid)
        else $error("result lost after load");

endmodule
